/* rtl/assert_macros.svh */
// assertion macros used by the top level of the moving-sum filter bank
// depends on nothing; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is switched off while reset is high
`define MCMS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds while reset is high
`define MCMS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/mcms_pkg.sv */
// types and constants of the multichannel complex moving-sum filter bank
// depends on nothing; used by the interfaces and the top level
package mcms_pkg;

   // payload field types
   typedef logic signed [15:0] sample_type;
   typedef logic signed [31:0] sum_type;
   typedef logic        [5:0]  chan_idx_type;
   typedef logic signed [23:0] scaled_type;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // register indexes
   localparam csr_index_type CSR_WINDOW_LENGTH = 2'd0;
   localparam csr_index_type CSR_NUM_CHANNELS  = 2'd1;
   localparam csr_index_type CSR_SCALE_FACTOR  = 2'd2;

   // register reset values
   localparam logic [8:0]        WINDOW_LENGTH_RESET = 9'd256;
   localparam logic [6:0]        NUM_CHANNELS_RESET  = 7'd64;
   localparam logic signed [23:0] SCALE_FACTOR_RESET = 24'sd256;

endpackage

/* rtl/mcms_ifs.sv */
// valid/ready channel interfaces for sample requests and sum responses
// depends on mcms_pkg for the payload types
interface mcms_req_if;
   logic                valid;
   logic                ready;
   mcms_pkg::sample_type sample_re;
   mcms_pkg::sample_type sample_im;

   modport source (output valid, output sample_re, output sample_im, input ready);
   modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface mcms_rsp_if;
   logic                  valid;
   logic                  ready;
   mcms_pkg::sum_type      sum_re;
   mcms_pkg::sum_type      sum_im;
   mcms_pkg::chan_idx_type channel_index;
   logic                  frame_end;

   modport source (output valid, output sum_re, output sum_im, output channel_index,
                   output frame_end, input ready);
   modport sink   (input valid, input sum_re, input sum_im, input channel_index,
                   input frame_end, output ready);
endinterface

/* rtl/mcms_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read
// depends on nothing
module mcms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/multichannel_complex_moving_sum.sv */
// top level of the multichannel complex moving-sum (boxcar) filter bank
// depends on mcms_pkg, mcms_ifs (channels), mcms_ram and assert_macros.svh
//
//   port       dir   transfer when        payload
//   req_chan   in    valid & ready        sample_re, sample_im
//   rsp_chan   out   valid & ready        sum_re, sum_im, channel_index, frame_end
//   csr_*      in    csr_we               csr_index, csr_wdata
//
// one sample per clock sustained while rsp_chan keeps taking results; a result passes
// the registered read of the history and sum memories, then the output register
// reset, and any write to a defined register, clear the counters and two fill flags; entries
// not yet written since then read as zero, so no clearing pass runs over the memories
// a result waiting on rsp_chan holds stage one; req_chan.ready drops only when both are full
`include "assert_macros.svh"

module multichannel_complex_moving_sum #(
   parameter int MAX_CHANNELS = 64,
   parameter int MAX_WINDOW   = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   mcms_req_if.sink                req_chan,
   mcms_rsp_if.source              rsp_chan,
   input  logic                    csr_we,
   input  mcms_pkg::csr_index_type csr_index,
   input  mcms_pkg::csr_data_type  csr_wdata
);

   localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int HIST_DEPTH = MAX_WINDOW * MAX_CHANNELS;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int HIST_W     = 48;
   localparam int SUM_W      = 64;

   // effective window length minus one
   function automatic logic [POS_W-1:0] win_last(input logic [8:0] wl);
      int unsigned v;
      v = 32'(wl);
      if (v == 0 || v > MAX_WINDOW) return POS_W'(MAX_WINDOW - 1);
      return POS_W'(v - 1);
   endfunction

   // effective channel count minus one
   function automatic logic [CH_W-1:0] chan_last(input logic [6:0] nc);
      int unsigned v;
      v = 32'(nc);
      if (v == 0) return '0;
      if (v > MAX_CHANNELS) return CH_W'(MAX_CHANNELS - 1);
      return CH_W'(v - 1);
   endfunction

   // round half up from q16, then saturate to 24 bits
   function automatic mcms_pkg::scaled_type scale_round(input logic signed [39:0] prod);
      logic signed [40:0] rnd;
      logic signed [24:0] shr;
      rnd = 41'(prod) + 41'sd32768;
      shr = rnd[40:16];
      if (shr[24] != shr[23]) return shr[24] ? 24'sh800000 : 24'sh7FFFFF;
      return shr[23:0];
   endfunction

   // configuration and frame counters
   logic [POS_W-1:0]          win_m1_ff;
   logic [CH_W-1:0]           nch_m1_ff;
   logic signed [23:0]        scale_ff;
   logic [CH_W-1:0]           ch_ff;
   logic [POS_W-1:0]          pos_ff;
   logic [HIST_AW-1:0]        pos_base_ff;
   logic                      hist_fill_ff;
   logic                      sum_fill_ff;

   // stage one
   logic                      s1_valid_ff;
   logic [CH_W-1:0]           s1_ch_ff;
   logic                      s1_last_ff;
   logic [HIST_AW-1:0]        s1_idx_ff;
   logic signed [39:0]        s1_prod_re_ff;
   logic signed [39:0]        s1_prod_im_ff;
   logic                      s1_hist_zero_ff;
   logic                      s1_hist_fwd_ff;
   logic                      s1_sum_zero_ff;
   logic                      s1_sum_fwd_ff;

   // write bypass
   logic [HIST_W-1:0]         byp_hist_ff;
   logic [HIST_AW-1:0]        byp_hist_addr_ff;
   logic [SUM_W-1:0]          byp_sum_ff;

   // output register
   logic                      rsp_valid_ff;
   mcms_pkg::sum_type         rsp_sum_re_ff;
   mcms_pkg::sum_type         rsp_sum_im_ff;
   mcms_pkg::chan_idx_type    rsp_chan_ff;
   logic                      rsp_last_ff;

   logic                      accept;
   logic                      s1_adv;
   logic                      cfg_hit;
   logic                      last_in;
   logic [HIST_AW-1:0]        idx_in;
   logic signed [39:0]        prod_re_in;
   logic signed [39:0]        prod_im_in;
   logic [HIST_W-1:0]         hist_rd;
   logic [SUM_W-1:0]          sum_rd;
   logic [HIST_W-1:0]         hist_old;
   logic [SUM_W-1:0]          sum_old;
   mcms_pkg::scaled_type      new_re;
   mcms_pkg::scaled_type      new_im;
   mcms_pkg::scaled_type      old_re;
   mcms_pkg::scaled_type      old_im;
   mcms_pkg::sum_type         sum_re_in;
   mcms_pkg::sum_type         sum_im_in;
   logic [HIST_W-1:0]         hist_wr;
   logic [SUM_W-1:0]          sum_wr;

   // handshake
   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;
   assign cfg_hit        = csr_we && (csr_index == mcms_pkg::CSR_WINDOW_LENGTH ||
                                      csr_index == mcms_pkg::CSR_NUM_CHANNELS ||
                                      csr_index == mcms_pkg::CSR_SCALE_FACTOR);

   // history address and gain products
   assign idx_in     = pos_base_ff + HIST_AW'(ch_ff);
   assign last_in    = (ch_ff == nch_m1_ff);
   assign prod_re_in = 40'(req_chan.sample_re) * 40'(scale_ff);
   assign prod_im_in = 40'(req_chan.sample_im) * 40'(scale_ff);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_m1_ff <= win_last(mcms_pkg::WINDOW_LENGTH_RESET);
         nch_m1_ff <= chan_last(mcms_pkg::NUM_CHANNELS_RESET);
         scale_ff  <= mcms_pkg::SCALE_FACTOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mcms_pkg::CSR_WINDOW_LENGTH: win_m1_ff <= win_last(csr_wdata[8:0]);
            mcms_pkg::CSR_NUM_CHANNELS:  nch_m1_ff <= chan_last(csr_wdata[6:0]);
            mcms_pkg::CSR_SCALE_FACTOR:  scale_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // channel and window position counters with fill flags
   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         ch_ff        <= '0;
         pos_ff       <= '0;
         pos_base_ff  <= '0;
         hist_fill_ff <= 1'b0;
         sum_fill_ff  <= 1'b0;
      end else if (accept) begin
         if (last_in) begin
            ch_ff       <= '0;
            sum_fill_ff <= 1'b1;
            if (pos_ff == win_m1_ff) begin
               pos_ff       <= '0;
               pos_base_ff  <= '0;
               hist_fill_ff <= 1'b1;
            end else begin
               pos_ff      <= pos_ff + POS_W'(1);
               pos_base_ff <= pos_base_ff + HIST_AW'(MAX_CHANNELS);
            end
         end else begin
            ch_ff <= ch_ff + CH_W'(1);
         end
      end
   end

   // stage one control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // stage one payload, forwarding marks against the write of this edge
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ch_ff        <= ch_ff;
         s1_last_ff      <= last_in;
         s1_idx_ff       <= idx_in;
         s1_prod_re_ff   <= prod_re_in;
         s1_prod_im_ff   <= prod_im_in;
         s1_hist_zero_ff <= !hist_fill_ff;
         s1_sum_zero_ff  <= !sum_fill_ff;
         s1_hist_fwd_ff  <= s1_adv && (s1_idx_ff == idx_in);
         s1_sum_fwd_ff   <= s1_adv && (s1_ch_ff == ch_ff);
      end
   end

   // history and running sum memories
   mcms_ram #(.WIDTH(HIST_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_idx_ff),
      .wr_data (hist_wr),
      .rd_en   (accept),
      .rd_addr (idx_in),
      .rd_data (hist_rd)
   );

   mcms_ram #(.WIDTH(SUM_W), .DEPTH(MAX_CHANNELS)) u_sum_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_ch_ff),
      .wr_data (sum_wr),
      .rd_en   (accept),
      .rd_addr (ch_ff),
      .rd_data (sum_rd)
   );

   // old entries: unwritten reads as zero, else bypass, else memory
   always_comb begin
      if (s1_hist_zero_ff) begin
         hist_old = '0;
      end else if (s1_hist_fwd_ff) begin
         hist_old = byp_hist_ff;
      end else begin
         hist_old = hist_rd;
      end
      if (s1_sum_zero_ff) begin
         sum_old = '0;
      end else if (s1_sum_fwd_ff) begin
         sum_old = byp_sum_ff;
      end else begin
         sum_old = sum_rd;
      end
   end

   // scale the sample and update the sums
   assign new_re    = scale_round(s1_prod_re_ff);
   assign new_im    = scale_round(s1_prod_im_ff);
   assign old_re    = hist_old[23:0];
   assign old_im    = hist_old[47:24];
   assign sum_re_in = sum_old[31:0] - 32'(old_re) + 32'(new_re);
   assign sum_im_in = sum_old[63:32] - 32'(old_im) + 32'(new_im);
   assign hist_wr   = {new_im, new_re};
   assign sum_wr    = {sum_im_in, sum_re_in};

   // bypass copy of the last write
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         byp_hist_ff      <= hist_wr;
         byp_hist_addr_ff <= s1_idx_ff;
         byp_sum_ff       <= sum_wr;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_sum_re_ff <= sum_re_in;
         rsp_sum_im_ff <= sum_im_in;
         rsp_chan_ff   <= 6'(s1_ch_ff);
         rsp_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.sum_re        = rsp_sum_re_ff;
   assign rsp_chan.sum_im        = rsp_sum_im_ff;
   assign rsp_chan.channel_index = rsp_chan_ff;
   assign rsp_chan.frame_end     = rsp_last_ff;

   // checks
   `MCMS_ASSERT(a_ch_range, clock, reset, ch_ff <= nch_m1_ff, "channel counter out of range")
   `MCMS_ASSERT(a_pos_range, clock, reset, pos_ff <= win_m1_ff, "window position out of range")
   `MCMS_ASSERT(a_hist_fwd_addr, clock, reset, s1_valid_ff && s1_hist_fwd_ff |-> s1_idx_ff == byp_hist_addr_ff, "history bypass address mismatch")
   `MCMS_ASSERT(a_fill_at_wrap, clock, reset, $rose(hist_fill_ff) |-> pos_ff == '0 && ch_ff == '0, "history fill flag set away from window wrap")
   `MCMS_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !s1_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")

endmodule
